// ===== design/cfl_pkg.sv =====
// Types and constants shared by the log-Cholesky covariance block.
`timescale 1ns / 1ps
package cfl_pkg;

	localparam int MAX_ROWS   = 8;
	localparam int MAX_PARAMS = MAX_ROWS * (MAX_ROWS + 1) / 2;
	localparam int ADDR_W     = 6;
	localparam int ACC_W      = 112;
	localparam int RED_W      = 72;
	localparam int TERM_W     = 107;

	localparam logic [63:0]        LN2_Q64      = 64'hB17217F7D1CF79AB;
	localparam logic signed [33:0] EXP_LIM      = 34'sd2621440;
	localparam logic [4:0]         TAYLOR_STEPS = 5'd20;
	localparam logic [31:0]        ONE_Q16      = 32'h0001_0000;
	localparam logic [ACC_W-1:0]   BIG_TERM     = 112'd1 << 100;
	localparam logic [63:0]        HALF_Q64     = 64'h8000_0000_0000_0000;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ELEM,
		S_RD_A,
		S_RD_B,
		S_MUL,
		S_ACC,
		S_RD_P,
		S_RD_D,
		S_XSET,
		S_RED,
		S_TMUL,
		S_TDIV,
		S_SCALE,
		S_SHIFT,
		S_ADDT,
		S_FIN
	} state_t;

	function automatic logic [ADDR_W-1:0] tri_base(input logic [3:0] r);
		logic [7:0] m;
		m = {4'd0, r} * ({4'd0, r} + 8'd1);
		return m[6:1];
	endfunction

endpackage

// ===== design/covariance_from_log_cholesky.sv =====
// Covariance L*L^T from a log-Cholesky factor on one shared multiplier.
//
//  channel | dir | beat
//  s_axis  | in  | tdata[31:0] param_value
//  m_axis  | out | tdata[63:0] cov_value, [66:64] row_index, [69:67] col_index; tlast
//  cfg     | in  | data[3:0] n_rows
//
// A beat carries one parameter; s_axis_tready is high only in the idle state.
// The final parameter of a set starts the emission of n*n elements. Each element
// runs the dot product and exp setup, exp range reduction, a 20-term Taylor series
// (four partial products and a divide by the term index per term), then scaling
// and output; the exp steps are skipped when the exp term is zero or saturated.
// The one 33x33 multiplier serves the dot product, series and scaling, and the
// single-port parameter memory all reads. Reset returns to idle with n_rows 1; a
// stalled output register holds its element until taken; the next one waits.
`timescale 1ns / 1ps
module covariance_from_log_cholesky (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] param_value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // [63:0] cov_value, [66:64] row_index, [69:67] col_index
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);
	import cfl_pkg::*;

	state_t state_q, state_d;

	logic [3:0]        n_q;
	logic [2:0]        nm1;
	logic [ADDR_W-1:0] load_q, total, wr_idx, load_next;
	logic [31:0]       mem_q [MAX_PARAMS];
	logic [ADDR_W-1:0] rd_addr;
	logic [31:0]       rd_data_q;
	logic [2:0]        row_q, col_q, ii, jj, k_q;
	logic              is_diag, s_acc, last_el, out_free;

	logic signed [ACC_W-1:0] acc_q;
	logic [31:0]             pa_q;
	logic signed [31:0]      p_q, p_sel;
	logic signed [33:0]      x_sel;
	logic                    zero_term, big_term;
	logic signed [RED_W-1:0] red_q;
	logic                    red_neg, red_ge;
	logic signed [6:0]       ek_q;
	logic [63:0]             t_q, sum_q, div_q, div_n;
	logic [4:0]              tn_q, rem_q, rem_n;
	logic [2:0]              part_q, part_prev, dcnt_q;
	logic [127:0]            wide_q, wide_n, pp;
	logic [TERM_W-1:0]       term_q, term_n, half;
	logic signed [7:0]       sh_s;
	logic [7:0]              sh_r;
	logic [31:0]             mag;
	logic signed [32:0]      mul_a, mul_b;
	logic signed [65:0]      mul_q;
	logic                    sat_hi, sat_lo;
	logic [63:0]             sat_val;

	logic        out_valid_q, out_last_q;
	logic [63:0] out_val_q;
	logic [2:0]  out_row_q, out_col_q;

	assign nm1       = 3'(n_q - 4'd1);
	assign total     = tri_base(n_q);
	assign wr_idx    = (load_q >= total) ? '0 : load_q;
	assign load_next = wr_idx + 6'd1;
	assign s_acc     = s_axis_tvalid && s_axis_tready;
	assign ii        = (row_q > col_q) ? row_q : col_q;
	assign jj        = (row_q > col_q) ? col_q : row_q;
	assign is_diag   = (row_q == col_q);
	assign last_el   = (row_q == nm1) && (col_q == nm1);
	assign out_free  = !out_valid_q || m_axis_tready;

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_col_q, out_row_q, out_val_q};
	assign m_axis_tlast  = out_last_q;

	always_comb begin
		case (state_q)
			S_RD_A:  rd_addr = tri_base({1'b0, ii}) + {3'd0, k_q};
			S_RD_B:  rd_addr = tri_base({1'b0, jj}) + {3'd0, k_q};
			S_RD_P:  rd_addr = tri_base({1'b0, ii}) + {3'd0, jj};
			S_RD_D:  rd_addr = tri_base({1'b0, jj}) + {3'd0, jj};
			default: rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_acc)
			mem_q[wr_idx] <= s_axis_tdata;
		rd_data_q <= mem_q[rd_addr];
	end

	always_comb begin
		x_sel = is_diag ? {rd_data_q[31], rd_data_q, 1'b0} : {{2{rd_data_q[31]}}, rd_data_q};
		p_sel = is_diag ? ONE_Q16 : p_q;
	end
	assign zero_term = (p_sel == 32'sd0) || (x_sel < -EXP_LIM);
	assign big_term  = (x_sel > EXP_LIM);
	assign red_neg   = red_q[RED_W-1];
	assign red_ge    = red_q >= $signed({8'd0, LN2_Q64});
	assign mag       = p_q[31] ? 32'(-p_q) : 32'(p_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MUL: begin
				mul_a = {pa_q[31], pa_q};
				mul_b = {rd_data_q[31], rd_data_q};
			end
			S_TMUL: begin
				mul_a = {1'b0, part_q[1] ? t_q[63:32] : t_q[31:0]};
				mul_b = {1'b0, part_q[0] ? red_q[63:32] : red_q[31:0]};
			end
			S_SCALE: begin
				mul_a = {1'b0, mag};
				mul_b = {1'b0, part_q[0] ? sum_q[63:32] : sum_q[31:0]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk)
		mul_q <= mul_a * mul_b;

	assign part_prev = part_q - 3'd1;
	always_comb begin
		case (part_prev[1:0])
			2'd0:    pp = {64'd0, mul_q[63:0]};
			2'd1:    pp = {32'd0, mul_q[63:0], 32'd0};
			2'd2:    pp = {32'd0, mul_q[63:0], 32'd0};
			default: pp = {mul_q[63:0], 64'd0};
		endcase
		wide_n = wide_q + pp;
	end

	always_comb begin
		logic [63:0] q;
		logic [4:0]  r;
		logic [5:0]  r6;
		q = div_q;
		r = rem_q;
		for (int b = 0; b < 8; b++) begin
			r6 = {r, q[63]};
			q  = {q[62:0], 1'b0};
			if (r6 >= {1'b0, tn_q}) begin
				r6   = r6 - {1'b0, tn_q};
				q[0] = 1'b1;
			end
			r = r6[4:0];
		end
		div_n = q;
		rem_n = r;
	end

	always_comb begin
		sh_s = {ek_q[6], ek_q} - 8'sd47;
		sh_r = 8'(-sh_s);
		half = '0;
		if (!sh_s[7]) begin
			term_n = {11'd0, wide_q[95:0]} << sh_s[3:0];
		end else begin
			half   = TERM_W'(1) << (sh_r[6:0] - 7'd1);
			term_n = ({11'd0, wide_q[95:0]} + half) >> sh_r[6:0];
		end
	end

	assign sat_hi  = !acc_q[ACC_W-1] && (|acc_q[ACC_W-2:63]);
	assign sat_lo  = acc_q[ACC_W-1] && !(&acc_q[ACC_W-2:63]);
	assign sat_val = sat_hi ? ~HALF_Q64 : (sat_lo ? HALF_Q64 : acc_q[63:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (s_acc && load_next == total) state_d = S_ELEM;
			S_ELEM:  state_d = (jj == 3'd0) ? S_RD_P : S_RD_A;
			S_RD_A:  state_d = S_RD_B;
			S_RD_B:  state_d = S_MUL;
			S_MUL:   state_d = S_ACC;
			S_ACC:   state_d = (k_q == jj - 3'd1) ? S_RD_P : S_RD_A;
			S_RD_P:  state_d = S_RD_D;
			S_RD_D:  state_d = S_XSET;
			S_XSET:  state_d = (zero_term || big_term) ? S_FIN : S_RED;
			S_RED:   if (!red_neg && !red_ge) state_d = S_TMUL;
			S_TMUL:  if (part_q == 3'd4) state_d = S_TDIV;
			S_TDIV:  if (dcnt_q == 3'd7)
					state_d = (tn_q == TAYLOR_STEPS) ? S_SCALE : S_TMUL;
			S_SCALE: if (part_q == 3'd2) state_d = S_SHIFT;
			S_SHIFT: state_d = S_ADDT;
			S_ADDT:  state_d = S_FIN;
			S_FIN:   if (out_free) state_d = last_el ? S_IDLE : S_ELEM;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= 4'd1;
			load_q      <= '0;
			row_q       <= '0;
			col_q       <= '0;
			k_q         <= '0;
			part_q      <= '0;
			dcnt_q      <= '0;
			tn_q        <= 5'd1;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (m_axis_tvalid && m_axis_tready)
				out_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready)
				load_q <= '0;
			else if (state_q == S_IDLE && s_acc)
				load_q <= (load_next == total) ? '0 : load_next;
			case (state_q)
				S_IDLE: if (s_acc && load_next == total) begin
					row_q <= '0;
					col_q <= '0;
				end
				S_ELEM: k_q <= '0;
				S_ACC:  k_q <= k_q + 3'd1;
				S_RED: if (!red_neg && !red_ge) begin
					tn_q   <= 5'd1;
					part_q <= '0;
				end
				S_TMUL: begin
					part_q <= part_q + 3'd1;
					if (part_q == 3'd4)
						dcnt_q <= '0;
				end
				S_TDIV: begin
					dcnt_q <= dcnt_q + 3'd1;
					if (dcnt_q == 3'd7) begin
						tn_q   <= tn_q + 5'd1;
						part_q <= '0;
					end
				end
				S_SCALE: part_q <= part_q + 3'd1;
				S_FIN: if (out_free) begin
					if (row_q == nm1) begin
						row_q <= '0;
						col_q <= col_q + 3'd1;
					end else begin
						row_q <= row_q + 3'd1;
					end
				end
				default: k_q <= k_q;
			endcase
			if (cfg_valid && cfg_ready) begin
				if (cfg_data == 4'd0)
					n_q <= 4'd1;
				else if (cfg_data > 4'(MAX_ROWS))
					n_q <= 4'(MAX_ROWS);
				else
					n_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_ELEM: acc_q <= '0;
			S_RD_B: pa_q <= rd_data_q;
			S_ACC:  acc_q <= acc_q + ACC_W'(mul_q);
			S_RD_D: p_q <= rd_data_q;
			S_XSET: begin
				p_q   <= p_sel;
				red_q <= {x_sel[23:0], 48'd0};
				ek_q  <= '0;
				if (!zero_term && big_term)
					acc_q <= p_sel[31] ? acc_q - $signed(BIG_TERM) : acc_q + $signed(BIG_TERM);
			end
			S_RED: begin
				if (red_neg) begin
					red_q <= red_q + $signed({8'd0, LN2_Q64});
					ek_q  <= ek_q - 7'sd1;
				end else if (red_ge) begin
					red_q <= red_q - $signed({8'd0, LN2_Q64});
					ek_q  <= ek_q + 7'sd1;
				end else begin
					t_q   <= HALF_Q64;
					sum_q <= HALF_Q64;
				end
			end
			S_TMUL: begin
				wide_q <= (part_q == 3'd0) ? '0 : wide_n;
				if (part_q == 3'd4) begin
					div_q <= wide_n[127:64];
					rem_q <= '0;
				end
			end
			S_TDIV: begin
				div_q <= div_n;
				rem_q <= rem_n;
				if (dcnt_q == 3'd7) begin
					t_q   <= div_n;
					sum_q <= sum_q + div_n;
				end
			end
			S_SCALE: wide_q <= (part_q == 3'd0) ? '0 : wide_n;
			S_SHIFT: term_q <= term_n;
			S_ADDT:  acc_q <= p_q[31] ? acc_q - $signed(ACC_W'(term_q))
			                          : acc_q + $signed(ACC_W'(term_q));
			S_FIN: if (out_free) begin
				out_val_q  <= sat_val;
				out_row_q  <= row_q;
				out_col_q  <= col_q;
				out_last_q <= last_el;
			end
			default: pa_q <= pa_q;
		endcase
	end

	a_load_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		load_q < total)
		else $error("load count beyond parameter set");

	a_taylor_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TDIV |-> (tn_q >= 5'd1 && tn_q <= TAYLOR_STEPS))
		else $error("Taylor term index out of range");

	a_reduced_arg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RED && state_d == S_TMUL) |->
			(red_q[RED_W-1:64] == '0 && red_q[63:0] < LN2_Q64))
		else $error("exp argument not reduced to [0, ln2)");

	a_index_in_matrix: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> (row_q <= nm1 && col_q <= nm1))
		else $error("element index outside matrix");

endmodule
